/* src/rgbp_pkg.sv */
// ----------------------------------------------------------------------------
// rgbp_pkg
// Shared types, constants and helpers for the grayscale frame packer.
// ----------------------------------------------------------------------------
package rgbp_pkg;

    localparam int MODULES_DEF     = 4;
    localparam int PIX_PER_MODULE  = 16;
    localparam int OUTS_PER_MODULE = 48;
    localparam int LEVEL_W         = 12;
    localparam int ROW_DATA_W      = 3 * LEVEL_W;
    localparam int WORD_W          = 64;
    localparam int ACC_W           = WORD_W + ROW_DATA_W;
    localparam int ACC_CNT_W       = 7;
    localparam int IN_DATA_W       = 72;

    localparam logic [1:0] COLOR_RGB = 2'd0;
    localparam logic [1:0] COLOR_BRG = 2'd1;
    localparam logic [1:0] COLOR_GRB = 2'd2;

    localparam logic [2:0] FUNC_SET_PIXEL  = 3'd0;
    localparam logic [2:0] FUNC_SET_XY     = 3'd1;
    localparam logic [2:0] FUNC_SET_ALL    = 3'd2;
    localparam logic [2:0] FUNC_SET_OUTPUT = 3'd3;
    localparam logic [2:0] FUNC_FLUSH      = 3'd4;

    localparam logic [1:0] REG_COLOR_ORDER = 2'd0;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRPIX,
        ST_FILL,
        ST_RMW_RD,
        ST_RMW_WR,
        ST_FL_RD,
        ST_FL_DATA
    } state_t;

    typedef struct packed {
        logic append;
        logic final_rows;
    } pk_ctrl_t;

    typedef struct packed {
        logic room;
        logic empty;
    } pk_stat_t;

    // serpentine 4x4 grid: odd rows run backwards
    function automatic logic [3:0] serp_pixel(input logic [1:0] x, input logic [1:0] y);
        serp_pixel = {x, (x[0] ? ~y : y)};
    endfunction

    // pixel row: output 0 in the low lane, output 2 in the high lane
    function automatic logic [ROW_DATA_W-1:0] pixel_word(
        input logic [1:0]         order,
        input logic [LEVEL_W-1:0] r,
        input logic [LEVEL_W-1:0] g,
        input logic [LEVEL_W-1:0] b
    );
        pixel_word = {b, g, r};
        if (order == COLOR_BRG) begin
            pixel_word = {g, r, b};
        end else if (order == COLOR_GRB) begin
            pixel_word = {b, r, g};
        end
    endfunction

endpackage

/* src/rgbp_level_ram.sv */
// ----------------------------------------------------------------------------
// rgbp_level_ram
// Level store, one pixel (three 12-bit levels) per row, registered read.
// ----------------------------------------------------------------------------
module rgbp_level_ram #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic                             aclk,
    input  logic                             we,
    input  logic [ADDR_W-1:0]                addr,
    input  logic [rgbp_pkg::ROW_DATA_W-1:0]  wdata,
    output logic [rgbp_pkg::ROW_DATA_W-1:0]  rdata
);
    import rgbp_pkg::*;

    logic [ROW_DATA_W-1:0] mem [DEPTH];
    logic [ROW_DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/rgbp_word_packer.sv */
// ----------------------------------------------------------------------------
// rgbp_word_packer
// Gearbox from 36-bit pixel rows to 64-bit frame words, with output register.
// ----------------------------------------------------------------------------
module rgbp_word_packer (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  rgbp_pkg::pk_ctrl_t               ctrl,
    input  logic [rgbp_pkg::ROW_DATA_W-1:0]  row_data,
    output rgbp_pkg::pk_stat_t               stat,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [rgbp_pkg::WORD_W-1:0]      m_tdata,   // [63:0] frame_word
    output logic                             m_tlast
);
    import rgbp_pkg::*;

    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic [ACC_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [WORD_W-1:0]    m_tdata_reg, m_tdata_next;
    logic                 m_tlast_reg, m_tlast_next;
    logic                 emit;
    logic [ACC_CNT_W-1:0] shamt;
    logic [ACC_W-1:0]     shifted;

    localparam logic [ACC_CNT_W-1:0] WORD_CNT = ACC_CNT_W'(WORD_W);
    localparam logic [ACC_CNT_W-1:0] ROW_CNT  = ACC_CNT_W'(ROW_DATA_W);

    assign emit    = (cnt_reg >= WORD_CNT) && (!m_tvalid_reg || m_tready);
    assign shamt   = cnt_reg - WORD_CNT;
    assign shifted = acc_reg >> shamt;

    always_comb begin
        acc_next      = acc_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        if (ctrl.append) begin
            acc_next = {acc_reg[WORD_W-1:0], row_data};
            cnt_next = cnt_reg + ROW_CNT;
        end else if (emit) begin
            cnt_next = cnt_reg - WORD_CNT;
        end
        if (emit) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = shifted[WORD_W-1:0];
            m_tlast_next  = ctrl.final_rows && (cnt_reg == WORD_CNT);
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            m_tlast_reg  <= 1'b0;
        end else begin
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tlast_reg  <= m_tlast_next;
        end
        acc_reg     <= acc_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign stat.room  = cnt_reg < WORD_CNT;
    assign stat.empty = cnt_reg == '0;
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tlast    = m_tlast_reg;

    a_append_room: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.append |-> cnt_reg < WORD_CNT)
        else $error("row appended with a full word pending");
    a_cnt_nibble: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg[1:0] == 2'b00)
        else $error("bit count off nibble alignment");
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> !ctrl.append)
        else $error("append and emit in the same cycle");

endmodule

/* src/rgb_led_grayscale_frame_packer.sv */
// ----------------------------------------------------------------------------
// rgb_led_grayscale_frame_packer
// Level store and frame serialiser for chained 48-output LED driver modules.
//
// Commands arrive on the s_ channel, one request per handshake; set requests
// produce nothing on m_. A flush request produces MODULES*9 64-bit words on
// the m_ channel, module 0 first, output 47 first, MSB first; m_tlast marks
// the final word, after which the drivers latch.
// Work per request, from acceptance to readiness for the next one:
//   set pixel / set xy: one row write, set output: read, modify, write of
//   one row, set all: one row write per cycle over every row,
//   flush: a row read and then an append for each row, the read held
//   while a full word waits in the gearbox for the output register, so
//   longer if the receiver stalls.
// The store is a single-port memory of MODULES*16 rows of 36 bits; every
// command goes through its one port, which sets the work above.
// After reset a clearing pass writes zero to every row, while s_tready
// stays low; APB writes are taken throughout.
// When m_tready is low the word in the output register holds, the gearbox
// stops pulling rows, and the flush resumes where it stopped.
// ----------------------------------------------------------------------------
module rgb_led_grayscale_frame_packer #(
    parameter int MODULES = rgbp_pkg::MODULES_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // APB configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [2:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    // command stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // func[2:0] pixel[6:3] x[8:7] y[10:9] module_req[12:11] channel[18:13]
    // level[30:19] red[42:31] green[54:43] blue[66:55], zero to [71]
    input  logic [rgbp_pkg::IN_DATA_W-1:0]     s_tdata,
    // frame stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [rgbp_pkg::WORD_W-1:0]        m_tdata,   // [63:0] frame_word
    output logic                               m_tlast
);
    import rgbp_pkg::*;

    localparam int ROWS  = MODULES * PIX_PER_MODULE;
    localparam int ROW_W = $clog2(ROWS);
    localparam int CNT_W = $clog2(ROWS + 1);
    localparam logic [CNT_W-1:0] ROWS_C = CNT_W'(ROWS);

    state_t state_reg, state_next;

    logic [CNT_W-1:0]      row_cnt_reg, row_cnt_next;
    logic [1:0]            color_order_reg;
    logic [ROW_W-1:0]      req_row_reg, req_row_next;
    logic [1:0]            req_lane_reg, req_lane_next;
    logic [LEVEL_W-1:0]    req_level_reg, req_level_next;
    logic [ROW_DATA_W-1:0] req_word_reg, req_word_next;
    logic                  req_ok_reg, req_ok_next;

    logic                  ram_we;
    logic [ROW_W-1:0]      ram_addr;
    logic [ROW_DATA_W-1:0] ram_wdata;
    logic [ROW_DATA_W-1:0] ram_rdata;

    pk_ctrl_t              pk_ctrl;
    pk_stat_t              pk_stat;

    logic [2:0]            in_func;
    logic [3:0]            in_pixel;
    logic [1:0]            in_x, in_y, in_mod;
    logic [5:0]            in_chan;
    logic [LEVEL_W-1:0]    in_level, in_red, in_green, in_blue;
    logic                  in_mod_ok;
    logic [11:0]           chan_prod;
    logic [3:0]            chan_row;
    logic [5:0]            chan_lane;
    logic                  cfg_wr;
    logic                  accept;

    assign in_func  = s_tdata[2:0];
    assign in_pixel = s_tdata[6:3];
    assign in_x     = s_tdata[8:7];
    assign in_y     = s_tdata[10:9];
    assign in_mod   = s_tdata[12:11];
    assign in_chan  = s_tdata[18:13];
    assign in_level = s_tdata[30:19];
    assign in_red   = s_tdata[42:31];
    assign in_green = s_tdata[54:43];
    assign in_blue  = s_tdata[66:55];

    assign in_mod_ok = 32'(in_mod) < MODULES;
    // channel / 3 by reciprocal, exact below 48
    assign chan_prod = 12'(in_chan) * 12'd43;
    assign chan_row  = chan_prod[10:7];
    assign chan_lane = in_chan - 6'(chan_row) * 6'd3;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // configuration
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_COLOR_ORDER[0]);
    assign prdata = (paddr[2] == REG_COLOR_ORDER[0]) ? {30'd0, color_order_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_order_reg <= COLOR_RGB;
        end else if (cfg_wr) begin
            color_order_reg <= (pwdata[1:0] == 2'd3) ? COLOR_RGB : pwdata[1:0];
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (row_cnt_reg == ROWS_C - 1'b1) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) begin
                    unique case (in_func)
                        FUNC_SET_PIXEL,
                        FUNC_SET_XY:     state_next = ST_WRPIX;
                        FUNC_SET_ALL:    state_next = ST_FILL;
                        FUNC_SET_OUTPUT: state_next = ST_RMW_RD;
                        FUNC_FLUSH:      state_next = ST_FL_RD;
                        default:         state_next = ST_IDLE;
                    endcase
                end
            end
            ST_WRPIX: state_next = ST_IDLE;
            ST_FILL: begin
                if (row_cnt_reg == ROWS_C - 1'b1) state_next = ST_IDLE;
            end
            ST_RMW_RD: state_next = req_ok_reg ? ST_RMW_WR : ST_IDLE;
            ST_RMW_WR: state_next = ST_IDLE;
            ST_FL_RD: begin
                if (row_cnt_reg == ROWS_C) begin
                    if (pk_stat.empty) state_next = ST_IDLE;
                end else if (pk_stat.room) begin
                    state_next = ST_FL_DATA;
                end
            end
            ST_FL_DATA: state_next = ST_FL_RD;
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        row_cnt_next   = row_cnt_reg;
        req_row_next   = req_row_reg;
        req_lane_next  = req_lane_reg;
        req_level_next = req_level_reg;
        req_word_next  = req_word_reg;
        req_ok_next    = req_ok_reg;
        ram_we         = 1'b0;
        ram_addr       = req_row_reg;
        ram_wdata      = req_word_reg;
        pk_ctrl        = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                ram_we       = 1'b1;
                ram_addr     = row_cnt_reg[ROW_W-1:0];
                ram_wdata    = '0;
                row_cnt_next = row_cnt_reg + 1'b1;
            end
            ST_IDLE: begin
                row_cnt_next   = '0;
                req_level_next = in_level;
                req_word_next  = pixel_word(color_order_reg, in_red, in_green, in_blue);
                req_lane_next  = chan_lane[1:0];
                if (in_func == FUNC_SET_XY) begin
                    req_row_next = ROW_W'({in_mod, serp_pixel(in_x, in_y)});
                    req_ok_next  = in_mod_ok;
                end else if (in_func == FUNC_SET_OUTPUT) begin
                    req_row_next = ROW_W'({in_mod, chan_row});
                    req_ok_next  = in_mod_ok && (in_chan < 6'(OUTS_PER_MODULE));
                end else begin
                    req_row_next = ROW_W'({in_mod, in_pixel});
                    req_ok_next  = in_mod_ok;
                end
            end
            ST_WRPIX: begin
                ram_we = req_ok_reg;
            end
            ST_FILL: begin
                ram_we       = 1'b1;
                ram_addr     = row_cnt_reg[ROW_W-1:0];
                row_cnt_next = row_cnt_reg + 1'b1;
            end
            ST_RMW_RD: begin
            end
            ST_RMW_WR: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                unique case (req_lane_reg)
                    2'd0:    ram_wdata[LEVEL_W-1:0]             = req_level_reg;
                    2'd1:    ram_wdata[2*LEVEL_W-1:LEVEL_W]     = req_level_reg;
                    2'd2:    ram_wdata[3*LEVEL_W-1:2*LEVEL_W]   = req_level_reg;
                    default: ram_wdata                          = ram_rdata;
                endcase
            end
            ST_FL_RD: begin
                // pixel 15 of each module first
                ram_addr           = row_cnt_reg[ROW_W-1:0] ^ ROW_W'(PIX_PER_MODULE - 1);
                pk_ctrl.final_rows = (row_cnt_reg == ROWS_C);
                if (row_cnt_reg != ROWS_C && pk_stat.room) begin
                    row_cnt_next = row_cnt_reg + 1'b1;
                end
            end
            ST_FL_DATA: begin
                pk_ctrl.append = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            row_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            row_cnt_reg <= row_cnt_next;
        end
        req_row_reg   <= req_row_next;
        req_lane_reg  <= req_lane_next;
        req_level_reg <= req_level_next;
        req_word_reg  <= req_word_next;
        req_ok_reg    <= req_ok_next;
    end

    rgbp_level_ram #(
        .DEPTH  (ROWS),
        .ADDR_W (ROW_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    rgbp_word_packer u_packer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (pk_ctrl),
        .row_data (ram_rdata),
        .stat     (pk_stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    a_fl_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FL_DATA |-> $past(state_reg) == ST_FL_RD)
        else $error("flush append without a preceding row read");
    a_rmw_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_RMW_WR |-> $past(state_reg) == ST_RMW_RD)
        else $error("level write-back without a preceding read");
    a_row_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        row_cnt_reg <= ROWS_C)
        else $error("row counter past the store");

endmodule

/* test/rgb_led_grayscale_frame_packer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_led_grayscale_frame_packer_tb
// Drives set and flush requests into the frame packer and checks every frame
// word it returns. A local copy of the level store and colour order predicts
// each flush. A short directed table runs first, then random phases, each
// under a set colour order. Streams stall at random; one phase is calm.
// ----------------------------------------------------------------------------
module rgb_led_grayscale_frame_packer_tb;

    import rgbp_pkg::*;

    localparam int MODULES     = MODULES_DEF;
    localparam int WORDS_PER_M = 9;
    localparam int FLUSH_WORDS = MODULES * WORDS_PER_M;
    localparam int SETTLE      = MODULES * 32 + 40;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASE_REQS  = 70;

    localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
    localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

    // packed so that func lands in the low bits of s_tdata
    typedef struct packed {
        logic [11:0] blue;
        logic [11:0] green;
        logic [11:0] red;
        logic [11:0] level;
        logic [5:0]  channel;
        logic [1:0]  module_req;
        logic [1:0]  y;
        logic [1:0]  x;
        logic [3:0]  pixel;
        logic [2:0]  func;
    } request_t;

    typedef struct packed {
        logic [63:0] frame_word;
        logic        last;
    } frame_word_t;

    typedef struct packed {
        logic        new_order;
        logic [1:0]  order;
        logic        fixed_frame;
        logic [63:0] fill;
        request_t    req;
    } table_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [IN_DATA_W-1:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [WORD_W-1:0] m_tdata;
    logic        m_tlast;

    logic [11:0] levels [MODULES][OUTS_PER_MODULE];
    logic [1:0]  colour_order;
    frame_word_t frame_words_due [$];
    frame_word_t word_due;
    table_row_t  directed [$];

    bit calm = 1'b0;
    int mismatches = 0;
    int requests_taken = 0;
    int flushes_taken = 0;
    int words_checked = 0;
    int cycles = 0;

    rgb_led_grayscale_frame_packer #(
        .MODULES (MODULES)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding", cycles,
                     frame_words_due.size());
            $display("tb: failure");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatches < 30) begin
            $display("[%0t] mismatch %s: got %h want %h", $time, what, got, want);
        end
        mismatches++;
    endtask

    // frame words leave on the m_ side; compare each with the oldest due
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (frame_words_due.size() == 0) begin
                report_mismatch("word with none due", m_tdata, '0);
            end else begin
                word_due = frame_words_due.pop_front();
                if (m_tdata !== word_due.frame_word) begin
                    report_mismatch("frame_word", m_tdata, word_due.frame_word);
                end
                if (m_tlast !== word_due.last) begin
                    report_mismatch("last", 64'(m_tlast), 64'(word_due.last));
                end
            end
            words_checked++;
        end
        m_tready <= calm || ($urandom_range(99) >= 33);
    end

    function automatic logic [3:0] serpentine_pixel(input logic [1:0] x, input logic [1:0] y);
        logic [15:0] row;
        case (x)
            2'd0: row = 16'h3210;
            2'd1: row = 16'h4567;
            2'd2: row = 16'hBA98;
            default: row = 16'hCDEF;
        endcase
        return row[y*4 +: 4];
    endfunction

    task automatic write_level(input int m, input int o, input logic [11:0] v);
        if (m < MODULES && o < OUTS_PER_MODULE) begin
            levels[m][o] = v;
        end
    endtask

    task automatic write_pixel(input int m, input logic [3:0] p, input request_t r);
        logic [11:0] a0, a1, a2;
        a0 = r.red;
        a1 = r.green;
        a2 = r.blue;
        if (colour_order == COLOR_BRG) begin
            a0 = r.blue;
            a1 = r.red;
            a2 = r.green;
        end else if (colour_order == COLOR_GRB) begin
            a0 = r.green;
            a1 = r.red;
            a2 = r.blue;
        end
        write_level(m, 3 * p, a0);
        write_level(m, 3 * p + 1, a1);
        write_level(m, 3 * p + 2, a2);
    endtask

    task automatic predict_request(input request_t r, input bit fixed_frame,
                                   input logic [63:0] fill);
        logic [575:0] frame;
        frame_word_t fw;
        case (r.func)
            FUNC_SET_PIXEL: write_pixel(r.module_req, r.pixel, r);
            FUNC_SET_XY: write_pixel(r.module_req, serpentine_pixel(r.x, r.y), r);
            FUNC_SET_ALL: begin
                for (int m = 0; m < MODULES; m++) begin
                    for (int p = 0; p < PIX_PER_MODULE; p++) begin
                        write_pixel(m, 4'(p), r);
                    end
                end
            end
            FUNC_SET_OUTPUT: write_level(r.module_req, r.channel, r.level);
            FUNC_FLUSH: begin
                flushes_taken++;
                for (int m = 0; m < MODULES; m++) begin
                    // output 47 ends up in the top bits, shifted out first
                    for (int o = 0; o < OUTS_PER_MODULE; o++) begin
                        frame[o*12 +: 12] = levels[m][o];
                    end
                    for (int w = 0; w < WORDS_PER_M; w++) begin
                        fw.frame_word = fixed_frame ? fill : frame[575 - 64*w -: 64];
                        fw.last = (m == MODULES - 1) && (w == WORDS_PER_M - 1);
                        frame_words_due.push_back(fw);
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic send_request(input request_t r, input bit fixed_frame,
                                input logic [63:0] fill);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(99) < 33) begin
            gap = $urandom_range(1, 4);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_DATA_W'(r);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        requests_taken++;
        predict_request(r, fixed_frame, fill);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * int'(idx));
        pwdata  <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // only while idle: all frame words in, and time for a set all to finish
    task automatic change_order(input logic [1:0] v);
        s_tvalid <= 1'b0;
        while (frame_words_due.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        apb_write(REG_COLOR_ORDER, 32'(v));
        colour_order = (v == 2'd3) ? COLOR_RGB : v;
    endtask

    function automatic request_t mk_req(input logic [2:0] func, input logic [3:0] pixel,
                                        input logic [1:0] x, input logic [1:0] y,
                                        input logic [1:0] m, input logic [5:0] ch,
                                        input logic [11:0] lvl, input logic [11:0] r,
                                        input logic [11:0] g, input logic [11:0] b);
        request_t q;
        q.func = func;
        q.pixel = pixel;
        q.x = x;
        q.y = y;
        q.module_req = m;
        q.channel = ch;
        q.level = lvl;
        q.red = r;
        q.green = g;
        q.blue = b;
        return q;
    endfunction

    function automatic request_t random_request();
        request_t q;
        int pick;
        q.pixel = 4'($urandom);
        q.x = 2'($urandom);
        q.y = 2'($urandom);
        q.module_req = 2'($urandom);
        q.channel = 6'($urandom);
        q.level = 12'($urandom);
        q.red = 12'($urandom);
        q.green = 12'($urandom);
        q.blue = 12'($urandom);
        pick = $urandom_range(99);
        if (pick < 24) q.func = FUNC_SET_PIXEL;
        else if (pick < 44) q.func = FUNC_SET_XY;
        else if (pick < 48) q.func = FUNC_SET_ALL;
        else if (pick < 74) q.func = FUNC_SET_OUTPUT;
        else if (pick < 90) q.func = FUNC_FLUSH;
        else q.func = 3'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
        return q;
    endfunction

    function automatic table_row_t row(input logic new_order, input logic [1:0] order,
                                       input logic fixed_frame, input logic [63:0] fill,
                                       input request_t r);
        table_row_t t;
        t.new_order = new_order;
        t.order = order;
        t.fixed_frame = fixed_frame;
        t.fill = fill;
        t.req = r;
        return t;
    endfunction

    initial begin
        request_t flush;
        logic [1:0] phase_order [5];

        flush = mk_req(FUNC_FLUSH, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        phase_order = '{COLOR_GRB, COLOR_RGB, 2'd3, COLOR_BRG, 2'($urandom_range(3))};

        // cleared store, then all ones, then all zero again
        directed.push_back(row(0, 0, 1, 64'h0, flush));
        directed.push_back(row(0, 0, 0, 0,
            mk_req(FUNC_SET_ALL, 0, 0, 0, 0, 0, 0, 12'hFFF, 12'hFFF, 12'hFFF)));
        directed.push_back(row(0, 0, 1, 64'hFFFF_FFFF_FFFF_FFFF, flush));
        directed.push_back(row(0, 0, 0, 0,
            mk_req(FUNC_SET_ALL, 4'hF, 3, 3, 3, 6'h3F, 12'hFFF, 0, 0, 0)));
        directed.push_back(row(0, 0, 1, 64'h0, flush));
        directed.push_back(row(0, 0, 0, 0,
            mk_req(FUNC_SET_PIXEL, 0, 0, 0, 0, 0, 0, 12'hFFF, 12'h000, 12'h800)));
        directed.push_back(row(0, 0, 0, 0,
            mk_req(FUNC_SET_PIXEL, 4'hF, 0, 0, 3, 0, 0, 12'h001, 12'h002, 12'h003)));
        directed.push_back(row(0, 0, 0, 0,
            mk_req(FUNC_SET_XY, 0, 3, 3, 2, 0, 0, 12'hABC, 12'hDEF, 12'h123)));
        directed.push_back(row(0, 0, 0, 0,
            mk_req(FUNC_SET_XY, 0, 1, 0, 1, 0, 0, 12'h456, 12'h789, 12'hFED)));
        directed.push_back(row(0, 0, 0, 0,
            mk_req(FUNC_SET_OUTPUT, 0, 0, 0, 1, 6'd47, 12'hABC, 0, 0, 0)));
        directed.push_back(row(0, 0, 0, 0,
            mk_req(FUNC_SET_OUTPUT, 0, 0, 0, 3, 6'd0, 12'hFFF, 0, 0, 0)));
        // channels past 47 must leave the store alone
        directed.push_back(row(0, 0, 0, 0,
            mk_req(FUNC_SET_OUTPUT, 0, 0, 0, 0, 6'd48, 12'hFFF, 0, 0, 0)));
        directed.push_back(row(0, 0, 0, 0,
            mk_req(FUNC_SET_OUTPUT, 0, 0, 0, 2, 6'd63, 12'hFFF, 0, 0, 0)));
        directed.push_back(row(0, 0, 0, 0,
            mk_req(FUNC_SPARE_LO, 4'hF, 3, 3, 3, 6'h3F, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF)));
        directed.push_back(row(0, 0, 0, 0,
            mk_req(FUNC_SPARE_HI, 4'h5, 2, 1, 0, 6'd5, 12'h111, 12'h222, 12'h333, 12'h444)));
        directed.push_back(row(0, 0, 0, 0, flush));
        directed.push_back(row(1, COLOR_BRG, 0, 0,
            mk_req(FUNC_SET_PIXEL, 4'd5, 0, 0, 0, 0, 0, 12'hF00, 12'h0F0, 12'h00F)));
        directed.push_back(row(0, 0, 0, 0, flush));
        directed.push_back(row(1, COLOR_GRB, 0, 0,
            mk_req(FUNC_SET_XY, 0, 2, 1, 0, 0, 0, 12'hF00, 12'h0F0, 12'h00F)));
        directed.push_back(row(0, 0, 0, 0,
            mk_req(FUNC_SET_ALL, 0, 0, 0, 1, 0, 0, 12'h111, 12'h222, 12'h333)));
        directed.push_back(row(0, 0, 0, 0,
            mk_req(FUNC_SET_OUTPUT, 0, 0, 0, 2, 6'd24, 12'h555, 0, 0, 0)));
        directed.push_back(row(0, 0, 0, 0, flush));
        // unused colour order falls back to red, green, blue
        directed.push_back(row(1, 2'd3, 0, 0,
            mk_req(FUNC_SET_PIXEL, 4'd8, 0, 0, 1, 0, 0, 12'hA00, 12'h0B0, 12'h00C)));
        directed.push_back(row(0, 0, 0, 0, flush));

        for (int m = 0; m < MODULES; m++) begin
            for (int o = 0; o < OUTS_PER_MODULE; o++) begin
                levels[m][o] = '0;
            end
        end
        colour_order = COLOR_RGB;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        apb_write(REG_COLOR_ORDER, 32'(COLOR_RGB));

        foreach (directed[i]) begin
            if (directed[i].new_order) begin
                change_order(directed[i].order);
            end
            send_request(directed[i].req, directed[i].fixed_frame, directed[i].fill);
        end

        for (int ph = 0; ph < 5; ph++) begin
            change_order(phase_order[ph]);
            calm = (ph == 2);
            for (int i = 0; i < PHASE_REQS; i++) begin
                send_request(random_request(), 0, '0);
            end
            send_request(flush, 0, '0);
            calm = 1'b0;
        end

        s_tvalid <= 1'b0;
        while (frame_words_due.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);

        $display("covered %0d requests incl. %0d flushes, all colour orders", requests_taken,
                 flushes_taken);
        $display("%0d frame words compared, %0d mismatches", words_checked, mismatches);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
